/* design/vna_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types, constants and helpers for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int VTX_BITS   = 10;
  localparam int NUM_VTX    = 1024;
  localparam int POS_BITS   = 16;
  localparam int SUM_BITS   = 48;
  localparam int CROSS_BITS = 35;
  localparam int NRM_BITS   = 16;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_TRI   = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef struct packed {
    logic                used;
    logic [SUM_BITS-1:0] sx;
    logic [SUM_BITS-1:0] sy;
    logic [SUM_BITS-1:0] sz;
  } sum_entry_t;

  typedef struct packed {
    logic done;
    logic degen;
  } nrm_stat_t;

  // Adds a cross product component to an accumulator, clamping at the
  // signed limits of the accumulator width.
  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0]   s,
                                                  input logic [CROSS_BITS-1:0] c);
    logic signed [SUM_BITS:0] t;
    logic [SUM_BITS-1:0]      r;
    t = (SUM_BITS+1)'($signed(s)) + (SUM_BITS+1)'($signed(c));
    if (t[SUM_BITS] != t[SUM_BITS-1]) begin
      r = t[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      r = t[SUM_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/vna_nrm.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vna_nrm
// Scales one accumulated normal to unit length in Q1.14: one-bit normalize
// steps, serial sum of squares, bit-serial square root and restoring divide.
// ----------------------------------------------------------------------------
module vna_nrm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [vna_pkg::SUM_BITS-1:0]  sx,
  input  logic [vna_pkg::SUM_BITS-1:0]  sy,
  input  logic [vna_pkg::SUM_BITS-1:0]  sz,
  output vna_pkg::nrm_stat_t            stat,
  output logic signed [vna_pkg::NRM_BITS-1:0] nx,
  output logic signed [vna_pkg::NRM_BITS-1:0] ny,
  output logic signed [vna_pkg::NRM_BITS-1:0] nz
);
  import vna_pkg::*;

  typedef enum logic [7:0] {
    N_IDLE  = 8'b0000_0001,
    N_MAX   = 8'b0000_0010,
    N_SHIFT = 8'b0000_0100,
    N_SQ    = 8'b0000_1000,
    N_SQRT  = 8'b0001_0000,
    N_DLOAD = 8'b0010_0000,
    N_DIV   = 8'b0100_0000,
    N_DONE  = 8'b1000_0000
  } nstate_t;

  nstate_t             state;
  logic [SUM_BITS-1:0] m0, m1, m2;
  logic [2:0]          neg;
  logic [1:0]          idx;
  logic [1:0]          ci;
  logic [61:0]         tot;
  logic [62:0]         sn, res, sbit;
  logic [45:0]         rem, dv;
  logic [13:0]         q;
  logic [3:0]          k;
  logic                degen;

  logic [SUM_BITS-1:0] mx, mc;
  logic [59:0]         sq;
  logic [62:0]         trial;
  logic [30:0]         r;
  logic                qb;
  logic [14:0]         qv;
  logic [NRM_BITS-1:0] comp, nval;
  logic                cneg;

  always_comb begin
    unique case (idx)
      2'd0:    mx = m0;
      2'd1:    mx = m1;
      default: mx = m2;
    endcase
    unique case (ci)
      2'd0:    begin mc = m0; cneg = neg[0]; end
      2'd1:    begin mc = m1; cneg = neg[1]; end
      default: begin mc = m2; cneg = neg[2]; end
    endcase
    sq    = mc[29:0] * mc[29:0];
    trial = res + sbit;
    r     = res[30:0];
    qb    = (rem >= dv);
    qv    = {q, qb};
    comp  = {1'b0, qv};
    nval  = cneg ? (~comp + 16'd1) : comp;
  end

  assign stat.done  = (state == N_DONE);
  assign stat.degen = degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (start) begin
            m0    <= sx[SUM_BITS-1] ? (~sx + 48'd1) : sx;
            m1    <= sy[SUM_BITS-1] ? (~sy + 48'd1) : sy;
            m2    <= sz[SUM_BITS-1] ? (~sz + 48'd1) : sz;
            neg   <= {sz[SUM_BITS-1], sy[SUM_BITS-1], sx[SUM_BITS-1]};
            state <= N_MAX;
          end
        end
        N_MAX: begin
          if (m0 >= m1 && m0 >= m2) begin
            idx <= 2'd0;
          end else if (m1 >= m2) begin
            idx <= 2'd1;
          end else begin
            idx <= 2'd2;
          end
          if ((m0 | m1 | m2) == '0) begin
            degen <= 1'b1;
            nx    <= '0;
            ny    <= '0;
            nz    <= '0;
            state <= N_DONE;
          end else begin
            degen <= 1'b0;
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          // Bring the largest magnitude into [2^29, 2^30), one bit a cycle.
          if (mx[SUM_BITS-1:30] != '0) begin
            m0 <= m0 >> 1;
            m1 <= m1 >> 1;
            m2 <= m2 >> 1;
          end else if (!mx[29]) begin
            m0 <= m0 << 1;
            m1 <= m1 << 1;
            m2 <= m2 << 1;
          end else begin
            tot   <= '0;
            ci    <= 2'd0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          tot <= tot + 62'(sq);
          if (ci == 2'd2) begin
            sn    <= tot + 62'(sq);
            res   <= '0;
            sbit  <= {1'b1, 62'b0};
            state <= N_SQRT;
          end else begin
            ci <= ci + 2'd1;
          end
        end
        N_SQRT: begin
          if (sn >= trial) begin
            sn  <= sn - trial;
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit[0]) begin
            ci    <= 2'd0;
            state <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          rem   <= 46'({mc[29:0], 14'b0}) + 46'(r[30:1]);
          dv    <= 46'({r, 14'b0});
          q     <= '0;
          k     <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          if (qb) begin
            rem <= rem - dv;
          end
          q  <= qv[13:0];
          dv <= dv >> 1;
          k  <= k + 4'd1;
          if (k == 4'd14) begin
            unique case (ci)
              2'd0:    nx <= $signed(nval);
              2'd1:    ny <= $signed(nval);
              default: nz <= $signed(nval);
            endcase
            if (ci == 2'd2) begin
              state <= N_DONE;
            end else begin
              ci    <= ci + 2'd1;
              state <= N_DLOAD;
            end
          end
        end
        N_DONE: begin
          state <= N_IDLE;
        end
        default: begin
          state <= N_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/vertex_normal_accumulator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Area-weighted per-vertex normals: position store, accumulator store with
// read-modify-write, and a serial normalizing unit for readout.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Word
//  request   in         in_valid/in_stall   req_type, vtx_index, coord_*, corner_*
//  normal    out        out_valid/out_stall read_index, normal_*, used, degenerate
//
//  Load writes the position store directly; add triangle does three position reads,
//  the cross product, then three accumulator read-modify-writes.
//  Readout runs through the normalizing unit: up to 29 one-bit shifts,
//  32 square root steps and three 15-step divides.
//  Clear, and reset, run a clearing pass over the accumulator memory;
//  no request word is taken meanwhile.
//  A stalled result sits in the output register while the next word enters.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic [vna_pkg::VTX_BITS-1:0]      vtx_index,
  input  logic signed [vna_pkg::POS_BITS-1:0] coord_x,
  input  logic signed [vna_pkg::POS_BITS-1:0] coord_y,
  input  logic signed [vna_pkg::POS_BITS-1:0] coord_z,
  input  logic [vna_pkg::VTX_BITS-1:0]      corner_a,
  input  logic [vna_pkg::VTX_BITS-1:0]      corner_b,
  input  logic [vna_pkg::VTX_BITS-1:0]      corner_c,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vna_pkg::VTX_BITS-1:0]      read_index,
  output logic signed [vna_pkg::NRM_BITS-1:0] normal_x,
  output logic signed [vna_pkg::NRM_BITS-1:0] normal_y,
  output logic signed [vna_pkg::NRM_BITS-1:0] normal_z,
  output logic                              used,
  output logic                              degenerate
);
  import vna_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_POS    = 12'b0000_0000_0100,
    S_DIFF   = 12'b0000_0000_1000,
    S_MUL    = 12'b0000_0001_0000,
    S_CROSS  = 12'b0000_0010_0000,
    S_ACC_RD = 12'b0000_0100_0000,
    S_ACC_WR = 12'b0000_1000_0000,
    S_RD_SUM = 12'b0001_0000_0000,
    S_RD_CHK = 12'b0010_0000_0000,
    S_NORM   = 12'b0100_0000_0000,
    S_OUT    = 12'b1000_0000_0000
  } state_t;

  state_t                state;
  logic [1:0]            cnt;
  logic [VTX_BITS-1:0]   clr_addr;
  logic [VTX_BITS-1:0]   ka, kb, kc, vi;
  logic [3*POS_BITS-1:0] pa, pb, pc;
  logic signed [POS_BITS:0]     ux, uy, uz, wx, wy, wz;
  logic signed [2*POS_BITS+1:0] p0, p1, p2, p3, p4, p5;
  logic signed [CROSS_BITS-1:0] cx, cy, cz;
  logic signed [NRM_BITS-1:0]   res_x, res_y, res_z;
  logic                         res_used, res_degen;

  logic [3*POS_BITS-1:0] pos_mem [NUM_VTX];
  logic [3*POS_BITS-1:0] pos_q;
  sum_entry_t            sum_mem [NUM_VTX];
  sum_entry_t            sum_q;

  logic                  acc;
  logic [VTX_BITS-1:0]   ksel, sum_raddr, sum_waddr;
  logic                  sum_we;
  sum_entry_t            sum_wdata, upd;
  logic                  nrm_start;
  nrm_stat_t             nrm_stat;
  logic signed [NRM_BITS-1:0] nrm_x, nrm_y, nrm_z;
  logic                  out_load;

  assign in_stall = (state != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);
  assign nrm_start = (state == S_RD_CHK) && sum_q.used;

  always_comb begin
    unique case (cnt)
      2'd0:    ksel = ka;
      2'd1:    ksel = kb;
      default: ksel = kc;
    endcase
    upd.used  = 1'b1;
    upd.sx    = sat_add(sum_q.sx, cx);
    upd.sy    = sat_add(sum_q.sy, cy);
    upd.sz    = sat_add(sum_q.sz, cz);
    sum_raddr = (state == S_RD_SUM) ? vi : ksel;
    sum_waddr = (state == S_CLEAR) ? clr_addr : ksel;
    sum_we    = (state == S_CLEAR) || (state == S_ACC_WR);
    sum_wdata = (state == S_CLEAR) ? '0 : upd;
  end

  always_ff @(posedge clk) begin
    if (acc && req_t'(req_type) == REQ_LOAD) begin
      pos_mem[vtx_index] <= {coord_x, coord_y, coord_z};
    end
    pos_q <= pos_mem[ksel];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_q <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cnt      <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 10'd1;
          if (clr_addr == VTX_BITS'(NUM_VTX - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            unique case (req_t'(req_type))
              REQ_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              REQ_LOAD: begin
                state <= S_IDLE;
              end
              REQ_TRI: begin
                ka    <= corner_a;
                kb    <= corner_b;
                kc    <= corner_c;
                cnt   <= '0;
                state <= S_POS;
              end
              REQ_READ: begin
                vi    <= vtx_index;
                state <= S_RD_SUM;
              end
            endcase
          end
        end
        S_POS: begin
          // Read data arrives the cycle after its address is given.
          unique case (cnt)
            2'd0: ;
            2'd1: pa <= pos_q;
            2'd2: pb <= pos_q;
            2'd3: pc <= pos_q;
          endcase
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          ux    <= 17'($signed(pb[47:32])) - 17'($signed(pa[47:32]));
          uy    <= 17'($signed(pb[31:16])) - 17'($signed(pa[31:16]));
          uz    <= 17'($signed(pb[15:0]))  - 17'($signed(pa[15:0]));
          wx    <= 17'($signed(pc[47:32])) - 17'($signed(pa[47:32]));
          wy    <= 17'($signed(pc[31:16])) - 17'($signed(pa[31:16]));
          wz    <= 17'($signed(pc[15:0]))  - 17'($signed(pa[15:0]));
          state <= S_MUL;
        end
        S_MUL: begin
          p0    <= uy * wz;
          p1    <= uz * wy;
          p2    <= uz * wx;
          p3    <= ux * wz;
          p4    <= ux * wy;
          p5    <= uy * wx;
          state <= S_CROSS;
        end
        S_CROSS: begin
          cx    <= CROSS_BITS'(p0) - CROSS_BITS'(p1);
          cy    <= CROSS_BITS'(p2) - CROSS_BITS'(p3);
          cz    <= CROSS_BITS'(p4) - CROSS_BITS'(p5);
          cnt   <= '0;
          state <= S_ACC_RD;
        end
        S_ACC_RD: begin
          state <= S_ACC_WR;
        end
        S_ACC_WR: begin
          // The write lands before the next corner's read, so a repeated
          // corner sees its own earlier update.
          if (cnt == 2'd2) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt   <= cnt + 2'd1;
            state <= S_ACC_RD;
          end
        end
        S_RD_SUM: begin
          state <= S_RD_CHK;
        end
        S_RD_CHK: begin
          if (sum_q.used) begin
            state <= S_NORM;
          end else begin
            res_x     <= '0;
            res_y     <= '0;
            res_z     <= '0;
            res_used  <= 1'b0;
            res_degen <= 1'b0;
            state     <= S_OUT;
          end
        end
        S_NORM: begin
          if (nrm_stat.done) begin
            res_x     <= nrm_x;
            res_y     <= nrm_y;
            res_z     <= nrm_z;
            res_used  <= 1'b1;
            res_degen <= nrm_stat.degen;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_index <= vi;
      normal_x   <= res_x;
      normal_y   <= res_y;
      normal_z   <= res_z;
      used       <= res_used;
      degenerate <= res_degen;
    end
  end

  vna_nrm u_nrm (
    .clk   (clk),
    .rst   (rst),
    .start (nrm_start),
    .sx    (sum_q.sx),
    .sy    (sum_q.sy),
    .sz    (sum_q.sz),
    .stat  (nrm_stat),
    .nx    (nrm_x),
    .ny    (nrm_y),
    .nz    (nrm_z)
  );

  a_degen_used: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (used || !degenerate))
    else $error("degenerate flagged on an unused vertex");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (!used || degenerate)) |->
      (normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0))
    else $error("nonzero normal on unused or degenerate vertex");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
                   normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
                   normal_z <= 16'sd16384 && normal_z >= -16'sd16384))
    else $error("normal component beyond unit range");

  a_start_norm: assert property (@(posedge clk) disable iff (rst)
    nrm_start |=> (state == S_NORM))
    else $error("normalizer started outside readout");

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Vertex normal accumulator testbench
// Drives clear, load, triangle and readout words with random gaps and stalls.
// A scoreboard predicts each readout's normal and checks results in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vna_pkg::*;

  class normal_scoreboard;
    logic signed [15:0] px[NUM_VTX], py[NUM_VTX], pz[NUM_VTX];
    logic signed [63:0] acc_x[NUM_VTX], acc_y[NUM_VTX], acc_z[NUM_VTX];
    bit touched[NUM_VTX];
    logic [59:0] pending[$];
    int errors;

    function new();
      for (int i = 0; i < NUM_VTX; i++) begin
        px[i] = 0; py[i] = 0; pz[i] = 0;
        acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0; touched[i] = 0;
      end
      errors = 0;
    endfunction

    function logic signed [63:0] clamp_add(logic signed [63:0] s, logic signed [63:0] c);
      logic signed [63:0] hi, lo, t;
      hi = (64'sd1 <<< (SUM_BITS - 1)) - 1;
      lo = -hi - 1;
      t = s + c;
      if (t > hi) t = hi;
      if (t < lo) t = lo;
      return t;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void note_word(req_t rt, logic [9:0] vi, logic signed [15:0] x, y, z,
                            logic [9:0] a, b, c);
      logic signed [63:0] ux, uy, uz, wx, wy, wz, cx, cy, cz;
      logic signed [63:0] s[3];
      logic signed [15:0] nv[3];
      logic [63:0] m[3], mx, tot, r, q;
      logic [9:0] k[3];
      bit u, dg;
      case (rt)
        REQ_CLEAR: begin
          for (int i = 0; i < NUM_VTX; i++) begin
            acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0; touched[i] = 0;
          end
        end
        REQ_LOAD: begin
          px[vi] = x; py[vi] = y; pz[vi] = z;
        end
        REQ_TRI: begin
          k[0] = a; k[1] = b; k[2] = c;
          ux = px[b] - px[a]; uy = py[b] - py[a]; uz = pz[b] - pz[a];
          wx = px[c] - px[a]; wy = py[c] - py[a]; wz = pz[c] - pz[a];
          cx = uy * wz - uz * wy;
          cy = uz * wx - ux * wz;
          cz = ux * wy - uy * wx;
          for (int i = 0; i < 3; i++) begin
            acc_x[k[i]] = clamp_add(acc_x[k[i]], cx);
            acc_y[k[i]] = clamp_add(acc_y[k[i]], cy);
            acc_z[k[i]] = clamp_add(acc_z[k[i]], cz);
            touched[k[i]] = 1;
          end
        end
        default: begin
          nv[0] = 0; nv[1] = 0; nv[2] = 0;
          u = touched[vi];
          dg = 0;
          if (u) begin
            s[0] = acc_x[vi]; s[1] = acc_y[vi]; s[2] = acc_z[vi];
            for (int i = 0; i < 3; i++) m[i] = s[i] < 0 ? -s[i] : s[i];
            mx = m[0];
            if (m[1] > mx) mx = m[1];
            if (m[2] > mx) mx = m[2];
            if (mx == 0) begin
              dg = 1;
            end else begin
              while (mx >= (64'd1 << 30)) begin
                mx >>= 1;
                for (int i = 0; i < 3; i++) m[i] >>= 1;
              end
              while (mx < (64'd1 << 29)) begin
                mx <<= 1;
                for (int i = 0; i < 3; i++) m[i] <<= 1;
              end
              tot = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
              r = int_sqrt(tot);
              for (int i = 0; i < 3; i++) begin
                q = (m[i] * 16384 + r / 2) / r;
                nv[i] = s[i] < 0 ? -q[15:0] : q[15:0];
              end
            end
          end
          pending.insert(pending.size(), {vi, nv[0], nv[1], nv[2], u, dg});
        end
      endcase
    endfunction

    function void check_normal(logic [59:0] got);
      logic [59:0] exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected normal word %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (exp[59:50] != got[59:50])
        $display("%0t: read_index exp %0d got %0d", $time, exp[59:50], got[59:50]);
      if (exp[49:34] != got[49:34])
        $display("%0t: normal_x exp %0d got %0d", $time,
                 $signed(exp[49:34]), $signed(got[49:34]));
      if (exp[33:18] != got[33:18])
        $display("%0t: normal_y exp %0d got %0d", $time,
                 $signed(exp[33:18]), $signed(got[33:18]));
      if (exp[17:2] != got[17:2])
        $display("%0t: normal_z exp %0d got %0d", $time,
                 $signed(exp[17:2]), $signed(got[17:2]));
      if (exp[1] != got[1])
        $display("%0t: used exp %0d got %0d", $time, exp[1], got[1]);
      if (exp[0] != got[0])
        $display("%0t: degenerate exp %0d got %0d", $time, exp[0], got[0]);
      if (exp != got) errors++;
    endfunction
  endclass

  logic clk, rst, in_valid, in_stall, out_valid, out_stall, used, degenerate;
  logic [1:0] req_type;
  logic [9:0] vtx_index, corner_a, corner_b, corner_c, read_index;
  logic signed [15:0] coord_x, coord_y, coord_z, normal_x, normal_y, normal_z;

  normal_scoreboard sb;
  bit loaded[NUM_VTX];
  int loaded_list[$];
  int idle_cycles;
  bit hold_off, fast_sink;

  vertex_normal_accumulator dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Sends one word and waits for its acceptance, after an optional gap.
  // With no gap, valid stays high and the next word follows directly.
  task automatic send_word(req_t rt, logic [9:0] vi, logic signed [15:0] x, y, z,
                           logic [9:0] a, b, c, bit gaps);
    int gap;
    gap = 0;
    if (gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; req_type <= rt; vtx_index <= vi;
    coord_x <= x; coord_y <= y; coord_z <= z;
    corner_a <= a; corner_b <= b; corner_c <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(rt, vi, x, y, z, a, b, c);
    if (rt == REQ_LOAD && !loaded[vi]) begin
      loaded[vi] = 1;
      loaded_list.insert(loaded_list.size(), int'(vi));
    end
  endtask

  // Drops valid after the last accepted word before the sender waits.
  task automatic pause_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic load_vtx(int vi, int x, int y, int z);
    send_word(REQ_LOAD, 10'(vi), 16'(x), 16'(y), 16'(z), 10'd0, 10'd0, 10'd0, 1'b1);
  endtask

  task automatic add_tri(int a, int b, int c);
    send_word(REQ_TRI, 10'd0, 16'sd0, 16'sd0, 16'sd0, 10'(a), 10'(b), 10'(c), 1'b1);
  endtask

  task automatic read_vtx(int vi);
    send_word(REQ_READ, 10'(vi), 16'sd0, 16'sd0, 16'sd0, 10'd0, 10'd0, 10'd0, 1'b1);
  endtask

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // Receiver: random stalls, a long forced hold-off on request, and fast stretches.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_normal({read_index, normal_x, normal_y, normal_z, used, degenerate});
      if (hold_off) out_stall <= 1;
      else if (fast_sink) out_stall <= 0;
      else out_stall <= ($urandom_range(0, 19) == 0) ? 1 : ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int v, r;
    sb = new();
    rst = 1; in_valid = 0; req_type = REQ_CLEAR; vtx_index = 0;
    coord_x = 0; coord_y = 0; coord_z = 0; corner_a = 0; corner_b = 0; corner_c = 0;
    hold_off = 0; fast_sink = 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // Directed: extreme positions, readout of an unused vertex, repeated corner.
    load_vtx(0, 0, 0, 0);
    load_vtx(1, 16'sh7FFF, -32768, 16'sh7FFF);
    load_vtx(2, -32768, 16'sh7FFF, -32768);
    load_vtx(1023, 256, 0, 0);
    load_vtx(1022, 0, 256, 0);
    read_vtx(5);
    read_vtx(1023);
    add_tri(0, 1, 2);
    add_tri(0, 1023, 1022);
    add_tri(0, 0, 1);
    read_vtx(0); read_vtx(1); read_vtx(1023);
    // Accumulate onto vertex 1 by repeating a huge triangle.
    load_vtx(3, -32768, -32768, 16'sh7FFF);
    repeat (6) add_tri(1, 2, 3);
    read_vtx(1); read_vtx(3);
    send_word(REQ_CLEAR, 10'd0, 16'sd0, 16'sd0, 16'sd0, 10'd0, 10'd0, 10'd0, 1'b1);
    read_vtx(1);
    add_tri(1, 1, 1);
    read_vtx(1);

    // Long receiver hold-off while the sender keeps offering readouts.
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) read_vtx(i % 4);
    join
    // Sender pauses until every expected normal has arrived.
    pause_input();
    while (sb.pending.size() != 0) @(posedge clk);

    // Random: mostly meshes of loaded vertices with rare full clears now and then.
    for (int n = 0; n < 1000; n++) begin
      fast_sink = (n % 200) < 40;
      r = $urandom_range(0, 99);
      if (r < 25 || loaded_list.size() < 3) begin
        v = $urandom_range(0, 1023);
        if ($urandom_range(0, 3) == 0) v = pick_loaded();
        send_word(REQ_LOAD, 10'(v), 16'($urandom), 16'($urandom), 16'($urandom),
                  10'd0, 10'd0, 10'd0, n % 50 > 10);
      end else if (r < 60) begin
        v = pick_loaded();
        send_word(REQ_TRI, 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  10'(v), ($urandom_range(0, 9) == 0) ? 10'(v) : 10'(pick_loaded()),
                  10'(pick_loaded()), n % 50 > 10);
      end else if (r < 99) begin
        v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : pick_loaded();
        send_word(REQ_READ, 10'(v), 16'($urandom), 16'($urandom), 16'($urandom),
                  10'($urandom), 10'($urandom), 10'($urandom), n % 50 > 10);
      end else begin
        send_word(REQ_CLEAR, 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  10'($urandom), 10'($urandom), 10'($urandom), 1'b1);
      end
    end

    pause_input();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* vertex_normal_accumulator.f */
design/vna_pkg.sv
design/vna_nrm.sv
design/vertex_normal_accumulator.sv
tb/sv/testbench.sv
